// ===== hdl/pdm_pkg.sv =====
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared widths, register codes, reset gains and types for the pitch/depth
// vertical thruster mixer.
// ----------------------------------------------------------------------------
package pdm_pkg;

   // field widths
   localparam int ANGLE_W  = 17;
   localparam int DEPTH_W  = 24;
   localparam int ERR_W    = DEPTH_W + 1;
   localparam int PDIFF_W  = ANGLE_W + 1;
   localparam int D1_W     = ERR_W + 1;
   localparam int D2_W     = ERR_W + 2;
   localparam int GAIN_W   = 12;
   localparam int DRIVE_W  = 10;
   localparam int FRAC_W   = 12;

   // product widths (gain carried as a signed value with a zero sign bit)
   localparam int PP_W = GAIN_W + 1 + ANGLE_W;
   localparam int PD_W = GAIN_W + 1 + PDIFF_W;
   localparam int DP_W = GAIN_W + 1 + D1_W;
   localparam int DD_W = GAIN_W + 1 + D2_W;

   // bus widths
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;

   localparam int DRIVE_LIMIT_DEFAULT = 200;

   localparam logic [GAIN_W-1:0] PITCH_P_RESET = 12'd96;
   localparam logic [GAIN_W-1:0] PITCH_D_RESET = 12'd160;
   localparam logic [GAIN_W-1:0] DEPTH_P_RESET = 12'd304;
   localparam logic [GAIN_W-1:0] DEPTH_D_RESET = 12'd192;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PITCH_P = 2'd0,
      CSR_PITCH_D = 2'd1,
      CSR_DEPTH_P = 2'd2,
      CSR_DEPTH_D = 2'd3
   } pdm_csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] pitch_p;
      logic [GAIN_W-1:0] pitch_d;
      logic [GAIN_W-1:0] depth_p;
      logic [GAIN_W-1:0] depth_d;
   } pdm_gain_type;

   // per-stage load strobes of the pipeline
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } pdm_load_type;

endpackage

// ===== hdl/pdm_front.sv =====
// ----------------------------------------------------------------------------
// pdm_front
// Input stage: error history and the pitch/depth differences of one tick.
// ----------------------------------------------------------------------------
module pdm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic signed [pdm_pkg::ANGLE_W-1:0]    pitch_angle,
   input  logic        [pdm_pkg::DEPTH_W-1:0]    depth_measured,
   input  logic        [pdm_pkg::DEPTH_W-1:0]    depth_target,
   output logic signed [pdm_pkg::ANGLE_W-1:0]    angle_ff,
   output logic signed [pdm_pkg::PDIFF_W-1:0]    pdiff_ff,
   output logic signed [pdm_pkg::D1_W-1:0]       d1_ff,
   output logic signed [pdm_pkg::D2_W-1:0]       d2_ff
);
   import pdm_pkg::*;

   logic signed [ANGLE_W-1:0] prev_pitch_ff;
   logic signed [ERR_W-1:0]   err_last_ff;
   logic signed [ERR_W-1:0]   err_before_ff;

   logic signed [ERR_W-1:0]   err_in;
   logic signed [PDIFF_W-1:0] pdiff_in;
   logic signed [D1_W-1:0]    d1_in;
   logic signed [D2_W-1:0]    d2_in;

   always_comb begin
      err_in   = $signed({1'b0, depth_measured}) - $signed({1'b0, depth_target});
      pdiff_in = PDIFF_W'(pitch_angle) - PDIFF_W'(prev_pitch_ff);
      d1_in    = D1_W'(err_in) - D1_W'(err_last_ff);
      // e1 + e3 - 2*e2
      d2_in    = D2_W'(err_in) + D2_W'(err_before_ff) - (D2_W'(err_last_ff) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pitch_ff <= '0;
         err_last_ff   <= '0;
         err_before_ff <= '0;
      end else if (load) begin
         prev_pitch_ff <= pitch_angle;
         err_last_ff   <= err_in;
         err_before_ff <= err_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         angle_ff <= pitch_angle;
         pdiff_ff <= pdiff_in;
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
      end
   end

endmodule

// ===== hdl/pdm_mult.sv =====
// ----------------------------------------------------------------------------
// pdm_mult
// Gain stage: the four gain products, each registered.
// ----------------------------------------------------------------------------
module pdm_mult (
   input  logic                               clock,
   input  logic                               load,
   input  pdm_pkg::pdm_gain_type              gain,
   input  logic signed [pdm_pkg::ANGLE_W-1:0] angle,
   input  logic signed [pdm_pkg::PDIFF_W-1:0] pdiff,
   input  logic signed [pdm_pkg::D1_W-1:0]    d1,
   input  logic signed [pdm_pkg::D2_W-1:0]    d2,
   output logic signed [pdm_pkg::PP_W-1:0]    pp_ff,
   output logic signed [pdm_pkg::PD_W-1:0]    pd_ff,
   output logic signed [pdm_pkg::DP_W-1:0]    dp_ff,
   output logic signed [pdm_pkg::DD_W-1:0]    dd_ff
);
   import pdm_pkg::*;

   logic signed [PP_W-1:0] pp_in;
   logic signed [PD_W-1:0] pd_in;
   logic signed [DP_W-1:0] dp_in;
   logic signed [DD_W-1:0] dd_in;

   always_comb begin
      pp_in = PP_W'($signed({1'b0, gain.pitch_p}) * angle);
      pd_in = PD_W'($signed({1'b0, gain.pitch_d}) * pdiff);
      dp_in = DP_W'($signed({1'b0, gain.depth_p}) * d1);
      dd_in = DD_W'($signed({1'b0, gain.depth_d}) * d2);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pp_ff <= pp_in;
         pd_ff <= pd_in;
         dp_ff <= dp_in;
         dd_ff <= dd_in;
      end
   end

endmodule

// ===== hdl/pdm_mix.sv =====
// ----------------------------------------------------------------------------
// pdm_mix
// Sum, clamp, depth accumulator, truncation toward zero and thruster mixing.
// ----------------------------------------------------------------------------
module pdm_mix #(
   parameter int DRIVE_LIMIT = pdm_pkg::DRIVE_LIMIT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pdm_pkg::pdm_load_type              load,
   input  logic signed [pdm_pkg::PP_W-1:0]    pp,
   input  logic signed [pdm_pkg::PD_W-1:0]    pd,
   input  logic signed [pdm_pkg::DP_W-1:0]    dp,
   input  logic signed [pdm_pkg::DD_W-1:0]    dd,
   output logic signed [pdm_pkg::DRIVE_W-1:0] left_ff,
   output logic signed [pdm_pkg::DRIVE_W-1:0] right_ff
);
   import pdm_pkg::*;

   localparam int LIMIT_Q = DRIVE_LIMIT * (2 ** FRAC_W);
   localparam int ACC_W   = $clog2(LIMIT_Q + 1) + 1;
   localparam int TERM_W  = $clog2(DRIVE_LIMIT + 1) + 1;
   localparam int MIX_W   = TERM_W + 1;
   localparam int SAT_W   = (MIX_W > DRIVE_W) ? MIX_W : DRIVE_W;
   localparam int PSUM_W  = PD_W + 1;
   localparam int INC_W   = DD_W + 1;
   localparam int ASUM_W  = INC_W + 1;

   localparam logic signed [PSUM_W-1:0] P_HI = PSUM_W'(LIMIT_Q);
   localparam logic signed [PSUM_W-1:0] P_LO = -PSUM_W'(LIMIT_Q);
   localparam logic signed [ASUM_W-1:0] A_HI = ASUM_W'(LIMIT_Q);
   localparam logic signed [ASUM_W-1:0] A_LO = -ASUM_W'(LIMIT_Q);
   localparam logic signed [SAT_W-1:0]  S_HI = SAT_W'((2 ** (DRIVE_W - 1)) - 1);
   localparam logic signed [SAT_W-1:0]  S_LO = -SAT_W'(2 ** (DRIVE_W - 1));

   // stage 3
   logic signed [PSUM_W-1:0] psum;
   logic signed [ACC_W-1:0]  pitch_in, pitch_ff;
   logic signed [INC_W-1:0]  inc_in, inc_ff;
   // stage 4
   logic signed [ASUM_W-1:0] asum;
   logic signed [ACC_W-1:0]  accum_in, accum_ff;
   logic        [ACC_W-1:0]  pmag;
   logic signed [TERM_W-1:0] pterm_in, pterm_ff;
   // stage 5
   logic        [ACC_W-1:0]  dmag;
   logic signed [TERM_W-1:0] dterm;
   logic signed [SAT_W-1:0]  left_mix, right_mix;
   logic signed [DRIVE_W-1:0] left_in, right_in;

   always_comb begin
      psum = PSUM_W'(pp) + PSUM_W'(pd);
      if (psum > P_HI)
         pitch_in = ACC_W'(P_HI);
      else if (psum < P_LO)
         pitch_in = ACC_W'(P_LO);
      else
         pitch_in = ACC_W'(psum);
      inc_in = INC_W'(dp) + INC_W'(dd);
   end

   always_comb begin
      asum = ASUM_W'(accum_ff) + ASUM_W'(inc_ff);
      if (asum > A_HI)
         accum_in = ACC_W'(A_HI);
      else if (asum < A_LO)
         accum_in = ACC_W'(A_LO);
      else
         accum_in = ACC_W'(asum);
      // truncate toward zero: drop the fraction of the magnitude
      pmag     = pitch_ff[ACC_W-1] ? ACC_W'(-pitch_ff) : ACC_W'(pitch_ff);
      pterm_in = TERM_W'(pmag >> FRAC_W);
      if (pitch_ff[ACC_W-1])
         pterm_in = -pterm_in;
   end

   // accum_ff is both the loop state and the stage-4 payload
   always_comb begin
      dmag  = accum_ff[ACC_W-1] ? ACC_W'(-accum_ff) : ACC_W'(accum_ff);
      dterm = TERM_W'(dmag >> FRAC_W);
      if (accum_ff[ACC_W-1])
         dterm = -dterm;
      left_mix  = SAT_W'(dterm) - SAT_W'(pterm_ff);
      right_mix = SAT_W'(dterm) + SAT_W'(pterm_ff);
      if (left_mix > S_HI)
         left_in = DRIVE_W'(S_HI);
      else if (left_mix < S_LO)
         left_in = DRIVE_W'(S_LO);
      else
         left_in = DRIVE_W'(left_mix);
      if (right_mix > S_HI)
         right_in = DRIVE_W'(S_HI);
      else if (right_mix < S_LO)
         right_in = DRIVE_W'(S_LO);
      else
         right_in = DRIVE_W'(right_mix);
   end

   always_ff @(posedge clock) begin
      if (load.s3) begin
         pitch_ff <= pitch_in;
         inc_ff   <= inc_in;
      end
      if (load.s4)
         pterm_ff <= pterm_in;
      if (load.s5) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         accum_ff <= '0;
      else if (load.s4)
         accum_ff <= accum_in;
   end

endmodule

// ===== hdl/pitch_depth_pd_thruster_mixer_top.sv =====
// ----------------------------------------------------------------------------
// pitch_depth_pd_thruster_mixer_top
// Pitch PD and incremental depth PD controller mixed onto two vertical
// thrusters, one result transfer per control tick.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_*     in         pitch_angle, depth_measured, depth_target
//  rsp_*     out        left_vertical_drive, right_vertical_drive
//  csr_*     in         gain writes, index 0..3
//
//  Five-stage pipeline with rsp_tvalid taken from stage five; one transfer
//  per cycle is sustained while rsp_tready is high. The depth accumulator
//  closes its loop within stage four, so ticks follow back to back.
//  Each stage holds when the next one is full and stalled, so bubbles fill.
//  Reset clears the pipeline, error history and accumulator and loads the
//  default gains.
// ----------------------------------------------------------------------------
module pitch_depth_pd_thruster_mixer_top #(
   parameter int DRIVE_LIMIT = pdm_pkg::DRIVE_LIMIT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [16:0] pitch_angle, [40:17] depth_measured, [64:41] depth_target
   input  logic [pdm_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [9:0] left_vertical_drive, [19:10] right_vertical_drive
   output logic [pdm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [pdm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pdm_pkg::GAIN_W-1:0]         csr_wdata
);
   import pdm_pkg::*;

   pdm_gain_type gain_ff;
   logic [5:1]   valid_ff;
   logic [5:1]   ready;
   logic [4:0]   up_valid;
   pdm_load_type load;

   logic signed [ANGLE_W-1:0] angle;
   logic signed [PDIFF_W-1:0] pdiff;
   logic signed [D1_W-1:0]    d1;
   logic signed [D2_W-1:0]    d2;
   logic signed [PP_W-1:0]    pp;
   logic signed [PD_W-1:0]    pd;
   logic signed [DP_W-1:0]    dp;
   logic signed [DD_W-1:0]    dd;
   logic signed [DRIVE_W-1:0] left_drive, right_drive;

   // gain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff.pitch_p <= PITCH_P_RESET;
         gain_ff.pitch_d <= PITCH_D_RESET;
         gain_ff.depth_p <= DEPTH_P_RESET;
         gain_ff.depth_d <= DEPTH_D_RESET;
      end else if (csr_we) begin
         case (pdm_csr_index_type'(csr_index))
            CSR_PITCH_P: gain_ff.pitch_p <= csr_wdata;
            CSR_PITCH_D: gain_ff.pitch_d <= csr_wdata;
            CSR_DEPTH_P: gain_ff.depth_p <= csr_wdata;
            CSR_DEPTH_D: gain_ff.depth_d <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage handshake: a stage loads when empty or when it drains downstream
   always_comb begin
      up_valid = {valid_ff[4:1], req_tvalid};
      ready[5] = !valid_ff[5] || rsp_tready;
      for (int k = 4; k >= 1; k--)
         ready[k] = !valid_ff[k] || ready[k+1];
      load.s1 = ready[1] && up_valid[0];
      load.s2 = ready[2] && up_valid[1];
      load.s3 = ready[3] && up_valid[2];
      load.s4 = ready[4] && up_valid[3];
      load.s5 = ready[5] && up_valid[4];
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else begin
         for (int k = 1; k <= 5; k++)
            if (ready[k])
               valid_ff[k] <= up_valid[k-1];
      end
   end

   assign req_tready = ready[1];
   assign rsp_tvalid = valid_ff[5];
   assign rsp_tdata  = {4'b0, right_drive, left_drive};

   pdm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .load           (load.s1),
      .pitch_angle    ($signed(req_tdata[16:0])),
      .depth_measured (req_tdata[40:17]),
      .depth_target   (req_tdata[64:41]),
      .angle_ff       (angle),
      .pdiff_ff       (pdiff),
      .d1_ff          (d1),
      .d2_ff          (d2)
   );

   pdm_mult u_mult (
      .clock (clock),
      .load  (load.s2),
      .gain  (gain_ff),
      .angle (angle),
      .pdiff (pdiff),
      .d1    (d1),
      .d2    (d2),
      .pp_ff (pp),
      .pd_ff (pd),
      .dp_ff (dp),
      .dd_ff (dd)
   );

   pdm_mix #(
      .DRIVE_LIMIT (DRIVE_LIMIT)
   ) u_mix (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .pp       (pp),
      .pd       (pd),
      .dp       (dp),
      .dd       (dd),
      .left_ff  (left_drive),
      .right_ff (right_drive)
   );

endmodule
